FILE: rtl/assert_macros.svh
// Assertion helpers; the module using them must have clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define CHECK_PROP(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("check failed");

// Condition that must hold on every clock edge outside reset.
`define CHECK_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("invariant failed");

`endif

FILE: rtl/dtte_pkg.sv
package dtte_pkg;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic signed [63:0] epoch_value;
    logic               status;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_PARSE,
    ST_PREP,
    ST_DIV,
    ST_SUM,
    ST_MAC,
    ST_DONE
  } state_t;

  typedef struct packed {
    state_t     st;
    logic [4:0] step;
    logic       take;
  } cmd_t;

  typedef struct packed {
    logic last_fail;
    logic snap_mode;
    logic out_free;
  } stat_t;

  // Parser phases
  localparam logic [3:0] PH_YEAR     = 4'd0;
  localparam logic [3:0] PH_MONTH    = 4'd1;
  localparam logic [3:0] PH_DAY      = 4'd2;
  localparam logic [3:0] PH_HOUR     = 4'd3;
  localparam logic [3:0] PH_MIN      = 4'd4;
  localparam logic [3:0] PH_SEC      = 4'd5;
  localparam logic [3:0] PH_WAIT_DOT = 4'd6;
  localparam logic [3:0] PH_FRAC     = 4'd7;
  localparam logic [3:0] PH_DONE     = 4'd8;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [6:0] COUNT_CAP = 7'd64;

  localparam logic [4:0] DIV_LAST = 5'd0;
  localparam logic [4:0] SUM_LAST = 5'd5;
  localparam logic [2:0] MAC_LAST_TERM = 3'd4;
  localparam logic [1:0] MAC_LAST_PART = 2'd2;

  // -32167 - 2451545
  localparam logic signed [63:0] DAY_OFFSET = -64'sd2483712;

  localparam logic [63:0] USEC_PER_DAY  = 64'd86400000000;
  localparam logic [63:0] USEC_PER_HOUR = 64'd3600000000;
  localparam logic [63:0] USEC_PER_MIN  = 64'd60000000;
  localparam logic [63:0] USEC_PER_SEC  = 64'd1000000;

  // ceil(2^37 / 100): exact quotient by 100 for any 32-bit magnitude
  localparam logic [31:0] CENTURY_RECIP = 32'd1374389535;

  typedef struct packed {
    logic [3:0]         phase;
    logic [29:0]        acc;
    logic               neg;
    logic               sgn;
    logic [3:0]         cnt;
    logic [19:0]        frac;
    logic [2:0]         taken;
    logic               dot;
    logic               err;
    logic               we;
    logic [2:0]         widx;
    logic signed [30:0] wval;
  } pst_t;

endpackage

FILE: rtl/datetime_text_to_epoch_count_top.sv
// Bytes are taken one a cycle while the controller is in its parse state; after the
// last byte a date passes the prep, divide and six-step day sum states, a timestamp
// also the 15-step 32x32 multiply-accumulate, and a failed string goes straight to done.
// Bytes of the next string are taken while a result waits at the output.
// Reset (rst, synchronous): mode 0, parser at the year field, no result pending.
module datetime_text_to_epoch_count_top import dtte_pkg::*; #(
  parameter int MAX_TIMESTAMP_CHARS = 47,
  parameter int MAX_DATE_CHARS      = 15,
  parameter int FRACTION_DIGITS     = 6,
  parameter int NUMBER_DIGITS       = 9
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        char_valid,
  output logic        char_stall,
  input  in_word_t    char_word,
  output logic        result_valid,
  input  logic        result_stall,
  output out_word_t   result_word,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic  mode;
  cmd_t  cmd;
  stat_t stat;

  assign pready = 1'b1;
  assign prdata = {31'd0, mode};

  always_ff @(posedge clk) begin
    if (rst) mode <= 1'b0;
    else if (psel && penable && pwrite && paddr == 1'b0) mode <= pwdata[0];
  end

  dtte_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .last       (char_word.last),
    .char_stall (char_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  dtte_dp #(
    .MAX_TIMESTAMP_CHARS (MAX_TIMESTAMP_CHARS),
    .MAX_DATE_CHARS      (MAX_DATE_CHARS),
    .FRACTION_DIGITS     (FRACTION_DIGITS),
    .NUMBER_DIGITS       (NUMBER_DIGITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .mode         (mode),
    .char_word    (char_word),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_word  (result_word)
  );

endmodule

FILE: rtl/dtte_ctrl.sv
`include "assert_macros.svh"

module dtte_ctrl import dtte_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  char_valid,
  input  logic  last,
  output logic  char_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t     st, st_next;
  logic [4:0] step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= ST_PARSE;
      step <= '0;
    end else begin
      st   <= st_next;
      step <= step_next;
    end
  end

  always_comb begin
    st_next = st;
    case (st)
      ST_PARSE: begin
        if (char_valid && last) st_next = stat.last_fail ? ST_DONE : ST_PREP;
      end
      ST_PREP: st_next = ST_DIV;
      ST_DIV: begin
        if (step == DIV_LAST) st_next = ST_SUM;
      end
      ST_SUM: begin
        if (step == SUM_LAST) st_next = stat.snap_mode ? ST_DONE : ST_MAC;
      end
      ST_MAC: begin
        if (step[4:2] == MAC_LAST_TERM && step[1:0] == MAC_LAST_PART) st_next = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) st_next = ST_PARSE;
      end
      default: st_next = ST_PARSE;
    endcase
  end

  always_comb begin
    step_next = '0;
    if (st_next == st) begin
      case (st)
        ST_DIV, ST_SUM: step_next = step + 5'd1;
        ST_MAC: begin
          // upper bits: product term, low two bits: partial product
          if (step[1:0] == MAC_LAST_PART) step_next = {step[4:2] + 3'd1, 2'd0};
          else step_next = step + 5'd1;
        end
        default: step_next = '0;
      endcase
    end
  end

  always_comb begin
    char_stall = (st != ST_PARSE);
    cmd.st     = st;
    cmd.step   = step;
    cmd.take   = char_valid && (st == ST_PARSE);
  end

  `CHECK_PROP(a_div_len, (st == ST_DIV && step == DIV_LAST) |=> st == ST_SUM)
  `CHECK_PROP(a_last_ends, (cmd.take && last) |=> st != ST_PARSE)
  `CHECK_PROP(a_mac_ts_only, (st == ST_MAC) |-> !stat.snap_mode)

endmodule

FILE: rtl/dtte_dp.sv
module dtte_dp import dtte_pkg::*; #(
  parameter int MAX_TIMESTAMP_CHARS = 47,
  parameter int MAX_DATE_CHARS      = 15,
  parameter int FRACTION_DIGITS     = 6,
  parameter int NUMBER_DIGITS       = 9
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      mode,
  input  in_word_t  char_word,
  input  cmd_t      cmd,
  output stat_t     stat,
  output logic      result_valid,
  input  logic      result_stall,
  output out_word_t result_word
);

  function automatic logic is_dig(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic is_spc(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic pst_t clr_num(input pst_t s);
    pst_t r;
    r     = s;
    r.acc = '0;
    r.neg = 1'b0;
    r.sgn = 1'b0;
    r.cnt = '0;
    return r;
  endfunction

  function automatic pst_t store(input pst_t s);
    pst_t r;
    r      = s;
    r.we   = 1'b1;
    r.widx = s.phase[2:0];
    r.wval = s.neg ? -$signed({1'b0, s.acc}) : $signed({1'b0, s.acc});
    return clr_num(r);
  endfunction

  function automatic pst_t feed(input pst_t s, input logic [7:0] c, input logic md);
    pst_t       r;
    logic [3:0] dv;
    r    = s;
    r.we = 1'b0;
    dv   = 4'(c - CH_ZERO);
    if (!(s.err || s.phase >= PH_DONE)) begin
      if (s.phase <= PH_SEC) begin
        if (is_dig(c)) begin
          if (s.cnt >= 4'(NUMBER_DIGITS)) r.err = 1'b1;
          else begin
            r.acc = s.acc * 30'd10 + 30'(dv);
            r.cnt = s.cnt + 4'd1;
          end
        end else if (s.cnt == 4'd0) begin
          if (!s.sgn && is_spc(c)) r.err = 1'b0;
          else if (!s.sgn && (c == CH_PLUS || c == CH_MINUS)) begin
            r.sgn = 1'b1;
            r.neg = (c == CH_MINUS);
          end else r.err = 1'b1;
        end else begin
          r = store(s);
          case (s.phase)
            PH_YEAR, PH_MONTH: begin
              if (c == CH_MINUS) r.phase = s.phase + 4'd1;
              else r.err = 1'b1;
            end
            PH_HOUR, PH_MIN: begin
              if (c == CH_COLON) r.phase = s.phase + 4'd1;
              else r.err = 1'b1;
            end
            PH_DAY: begin
              if (md) r.phase = PH_DONE;
              else begin
                // same byte starts the hour field
                r.phase = PH_HOUR;
                if (is_dig(c)) begin
                  r.acc = 30'(dv);
                  r.cnt = 4'd1;
                end else if (is_spc(c)) r.err = 1'b0;
                else if (c == CH_PLUS || c == CH_MINUS) begin
                  r.sgn = 1'b1;
                  r.neg = (c == CH_MINUS);
                end else r.err = 1'b1;
              end
            end
            default: begin
              r.phase = PH_WAIT_DOT;
              if (c == CH_DOT) begin
                r.dot   = 1'b1;
                r.phase = PH_FRAC;
              end
            end
          endcase
        end
      end else if (s.phase == PH_WAIT_DOT) begin
        if (c == CH_DOT) begin
          r.dot   = 1'b1;
          r.phase = PH_FRAC;
        end
      end else begin
        if (is_dig(c) && s.taken < 3'(FRACTION_DIGITS)) begin
          r.frac  = s.frac * 20'd10 + 20'(dv);
          r.taken = s.taken + 3'd1;
          if (s.taken + 3'd1 >= 3'(FRACTION_DIGITS)) r.phase = PH_DONE;
        end else r.phase = PH_DONE;
      end
    end
    return r;
  endfunction

  function automatic pst_t fin(input pst_t s, input logic md);
    pst_t r;
    r    = s;
    r.we = 1'b0;
    if (!(s.err || s.phase >= PH_DONE)) begin
      if (s.phase > PH_SEC) r.phase = PH_DONE;
      else if (s.cnt == 4'd0) r.err = 1'b1;
      else begin
        r = store(s);
        if (s.phase == PH_SEC || (s.phase == PH_DAY && md)) r.phase = PH_DONE;
        else r.err = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic signed [63:0] tdiv4(input logic signed [63:0] x);
    return (x + (x < 0 ? 64'sd3 : 64'sd0)) >>> 2;
  endfunction

  function automatic logic signed [63:0] tdiv256(input logic signed [63:0] x);
    return (x + (x < 0 ? 64'sd255 : 64'sd0)) >>> 8;
  endfunction

  function automatic logic [19:0] frac_scale(input logic [2:0] k);
    case (k)
      3'd0:    return 20'd1000000;
      3'd1:    return 20'd100000;
      3'd2:    return 20'd10000;
      3'd3:    return 20'd1000;
      3'd4:    return 20'd100;
      3'd5:    return 20'd10;
      default: return 20'd1;
    endcase
  endfunction

  // ---------------- byte parser ----------------
  pst_t               ps, s1, s2, ps_clr;
  logic signed [30:0] fld [6];
  logic signed [30:0] fld_next [6];
  logic [6:0]         ccount, ccount_next;
  logic               last_fail;
  logic               is_last;

  always_comb begin
    ps_clr       = '0;
    ps_clr.phase = PH_YEAR;
    is_last      = cmd.take && char_word.last;
    s1 = (char_word.char_byte == CH_NUL) ? fin(ps, mode) : feed(ps, char_word.char_byte, mode);
    s2 = char_word.last ? fin(s1, mode) : s1;
    if (!char_word.last) s2.we = 1'b0;
    ccount_next = (ccount < COUNT_CAP) ? ccount + 7'd1 : ccount;
    for (int i = 0; i < 6; i++) begin
      fld_next[i] = fld[i];
      if (s1.we && s1.widx == 3'(i)) fld_next[i] = s1.wval;
      if (s2.we && s2.widx == 3'(i)) fld_next[i] = s2.wval;
    end
    last_fail = s2.err || (ccount_next > (mode ? 7'(MAX_DATE_CHARS) : 7'(MAX_TIMESTAMP_CHARS)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ps     <= ps_clr;
      ccount <= '0;
    end else if (cmd.take) begin
      ps     <= char_word.last ? ps_clr : s1;
      ccount <= char_word.last ? 7'd0 : ccount_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) fld <= fld_next;
  end

  // ---------------- snapshot of a finished string ----------------
  logic signed [30:0] sy, sm, sd, sh, smi, ss;
  logic [19:0]        sfrac;
  logic [2:0]         staken;
  logic               sdot, smode, sfail;

  always_ff @(posedge clk) begin
    if (is_last) begin
      sy     <= fld_next[0];
      sm     <= fld_next[1];
      sd     <= fld_next[2];
      sh     <= fld_next[3];
      smi    <= fld_next[4];
      ss     <= fld_next[5];
      sfrac  <= s2.frac;
      staken <= s2.taken;
      sdot   <= s2.dot;
      smode  <= mode;
      sfail  <= last_fail;
    end
  end

  // ---------------- date arithmetic ----------------
  logic signed [31:0] yadj, yadj_c, madj_c;
  logic signed [46:0] prodm;
  logic               yneg;
  logic [31:0]        dmag;
  logic [63:0]        cprod;
  logic signed [31:0] century;
  logic signed [40:0] p365;
  logic signed [63:0] term;
  logic signed [63:0] acc;
  logic [63:0]        macc;
  logic [63:0]        ma, mb, mp, madd;
  logic [31:0]        op_a, op_b;
  logic [2:0]         mterm;
  logic [1:0]         mpart;

  always_comb begin
    if (sm > 31'sd2) begin
      yadj_c = 32'(sy) + 32'sd4800;
      madj_c = 32'(sm) + 32'sd1;
    end else begin
      yadj_c = 32'(sy) + 32'sd4799;
      madj_c = 32'(sm) + 32'sd13;
    end
    // |adjusted year| / 100 by reciprocal multiplication, quotient in bits 63:37
    cprod   = 64'(dmag) * 64'(CENTURY_RECIP);
    century = yneg ? -$signed(dmag) : $signed(dmag);
    p365    = 41'(yadj) * 41'sd365;
    case (cmd.step[2:0])
      3'd0:    term = 64'(p365);
      3'd1:    term = 64'(sd) + DAY_OFFSET;
      3'd2:    term = tdiv4(64'(yadj));
      3'd3:    term = -64'(century);
      3'd4:    term = tdiv4(64'(century));
      3'd5:    term = tdiv256(64'(prodm));
      default: term = '0;
    endcase
    mterm = cmd.step[4:2];
    mpart = cmd.step[1:0];
    case (mterm)
      3'd0:    begin ma = acc;                          mb = USEC_PER_DAY;  end
      3'd1:    begin ma = 64'(sh);                      mb = USEC_PER_HOUR; end
      3'd2:    begin ma = 64'(smi);                     mb = USEC_PER_MIN;  end
      3'd3:    begin ma = 64'(ss);                      mb = USEC_PER_SEC;  end
      default: begin
        ma = {44'd0, sdot ? sfrac : 20'd0};
        mb = {44'd0, frac_scale(staken)};
      end
    endcase
    // product modulo 2^64 from three 32x32 partial products
    op_a = (mpart == 2'd2) ? ma[63:32] : ma[31:0];
    op_b = (mpart == 2'd1) ? mb[63:32] : mb[31:0];
    mp   = 64'(op_a) * 64'(op_b);
    madd = (mpart == 2'd0) ? mp : {mp[31:0], 32'd0};
  end

  always_ff @(posedge clk) begin
    case (cmd.st)
      ST_PREP: begin
        yadj  <= yadj_c;
        prodm <= 47'(madj_c) * 47'sd7834;
        yneg  <= yadj_c[31];
        dmag  <= yadj_c[31] ? 32'(-yadj_c) : 32'(yadj_c);
        acc   <= '0;
        macc  <= '0;
      end
      ST_DIV:  dmag <= {5'd0, cprod[63:37]};
      ST_SUM:  acc  <= acc + term;
      ST_MAC:  macc <= macc + madd;
      default: acc  <= acc;
    endcase
  end

  // ---------------- result register ----------------
  logic out_free;
  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else if (cmd.st == ST_DONE && out_free) result_valid <= 1'b1;
    else if (!result_stall) result_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.st == ST_DONE && out_free) begin
      result_word.epoch_value <= sfail ? 64'sd0 : (smode ? acc : $signed(macc));
      result_word.status      <= sfail;
    end
  end

  always_comb begin
    stat.last_fail = last_fail;
    stat.snap_mode = smode;
    stat.out_free  = out_free;
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import dtte_pkg::*;

  localparam bit MODE_STAMP = 1'b0;
  localparam bit MODE_DATE  = 1'b1;
  localparam logic [0:0] ADDR_MODE = 1'b0;
  localparam int STAMP_LIMIT = 47;
  localparam int DATE_LIMIT  = 15;
  localparam int FRAC_MAX    = 6;
  localparam int DIGIT_MAX   = 9;
  localparam int RANDOM_WORDS = 1240;

  // Predicts the epoch count of each text string, one character at a time.
  class epoch_scoreboard;
    bit mode;
    logic [3:0] phase;
    logic [29:0] acc;
    bit neg, sgn, dot, err;
    int cnt, taken, chars;
    int fields[6];
    logic [19:0] frac;
    out_word_t pending[$];
    int mismatches;

    function void clear();
      phase = PH_YEAR;
      acc = 0; neg = 0; sgn = 0; cnt = 0;
      foreach (fields[i]) fields[i] = 0;
      frac = 0; taken = 0; dot = 0; chars = 0; err = 0;
    endfunction

    function new();
      mode = MODE_STAMP;
      mismatches = 0;
      clear();
    endfunction

    function void store_field();
      fields[phase % 6] = neg ? -int'(acc) : int'(acc);
      acc = 0; neg = 0; sgn = 0; cnt = 0;
    endfunction

    function void feed(logic [7:0] c);
      logic [3:0] p;
      bit digit, space;
      digit = c >= CH_ZERO && c <= CH_NINE;
      space = c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
      forever begin
        if (err || phase >= PH_DONE) return;
        if (phase <= PH_SEC) begin
          if (digit) begin
            if (cnt >= DIGIT_MAX) err = 1;
            else begin
              acc = acc * 10 + (c - CH_ZERO);
              cnt++;
            end
            return;
          end
          if (cnt == 0) begin
            if (!sgn && space) return;
            if (!sgn && (c == CH_PLUS || c == CH_MINUS)) begin
              sgn = 1;
              neg = c == CH_MINUS;
              return;
            end
            err = 1;
            return;
          end
          p = phase;
          store_field();
          if (p <= PH_MONTH) begin
            if (c == CH_MINUS) phase++; else err = 1;
            return;
          end
          if (p == PH_HOUR || p == PH_MIN) begin
            if (c == CH_COLON) phase++; else err = 1;
            return;
          end
          if (p == PH_DAY) begin
            if (mode == MODE_DATE) begin
              phase = PH_DONE;
              return;
            end
            phase = PH_HOUR;   // day/hour gap: re-read this char as the hour
          end else begin
            phase = PH_WAIT_DOT;
          end
        end else if (phase == PH_WAIT_DOT) begin
          if (c == CH_DOT) begin
            dot = 1;
            phase = PH_FRAC;
          end
          return;
        end else begin
          if (digit && taken < FRAC_MAX) begin
            frac = frac * 10 + (c - CH_ZERO);
            taken++;
            if (taken >= FRAC_MAX) phase = PH_DONE;
          end else begin
            phase = PH_DONE;
          end
          return;
        end
      end
    endfunction

    function void end_text();
      logic [3:0] p;
      if (err || phase >= PH_DONE) return;
      if (phase > PH_SEC) begin
        phase = PH_DONE;
        return;
      end
      if (cnt == 0) begin
        err = 1;
        return;
      end
      p = phase;
      store_field();
      if (p == PH_SEC || (p == PH_DAY && mode == MODE_DATE)) phase = PH_DONE;
      else err = 1;
    endfunction

    function longint day_number(longint y, longint m, longint d);
      longint century, jd;
      if (m > 2) begin
        m += 1; y += 4800;
      end else begin
        m += 13; y += 4799;
      end
      century = y / 100;
      jd = y * 365 - 32167;
      jd += y / 4 - century + century / 4;
      jd += 7834 * m / 256 + d;
      return jd - 2451545;
    endfunction

    function void note_char(logic [7:0] c, logic last);
      bit fail;
      longint days;
      logic [63:0] usec, total;
      out_word_t w;
      if (chars < 64) chars++;
      if (c == CH_NUL) end_text(); else feed(c);
      if (!last) return;
      end_text();
      fail = err || chars > (mode == MODE_DATE ? DATE_LIMIT : STAMP_LIMIT);
      total = 0;
      if (!fail) begin
        days = day_number(fields[0], fields[1], fields[2]);
        if (mode == MODE_DATE) total = days;
        else begin
          usec = 0;
          if (dot) begin
            usec = frac;
            for (int k = taken; k < FRAC_MAX; k++) usec *= 10;
          end
          total = days * USEC_PER_DAY + longint'(fields[3]) * USEC_PER_HOUR
                + longint'(fields[4]) * USEC_PER_MIN
                + longint'(fields[5]) * USEC_PER_SEC + usec;
        end
      end
      w.epoch_value = fail ? 64'd0 : total;
      w.status = fail;
      pending.push_back(w);
      clear();
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d/%0d", got.epoch_value,
                                       got.status);
        return;
      end
      want = pending.pop_front();
      if (got.epoch_value !== want.epoch_value || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: value %0d exp %0d, status %0b exp %0b",
                   got.epoch_value, want.epoch_value, got.status, want.status);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic char_valid = 0;
  logic char_stall;
  in_word_t char_word = '0;
  logic result_valid;
  logic result_stall = 0;
  out_word_t result_word;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [0:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  epoch_scoreboard sb = new();
  logic [7:0] text_q[$];
  bit calm = 0;
  int words_sent = 0;

  datetime_text_to_epoch_count_top uut (
    .clk(clk), .rst(rst),
    .char_valid(char_valid), .char_stall(char_stall), .char_word(char_word),
    .result_valid(result_valid), .result_stall(result_stall),
    .result_word(result_word),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  always @(posedge clk) result_stall <= !calm && $urandom_range(0, 99) < 6;

  // stall and valid settle after the rising edge, so the falling edge sees the handshake
  always @(negedge clk)
    if (!rst && result_valid && !result_stall) sb.check_result(result_word);

  initial begin
    #10_000_000;
    $display("tb failed");
    $finish;
  end

  task automatic put_word(logic [7:0] c, logic last);
    bit s;
    if (!calm && $urandom_range(0, 99) < 6) begin
      char_valid <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    char_valid <= 1;
    char_word <= '{char_byte: c, last: last};
    do begin
      @(negedge clk);
      s = char_stall;
      @(posedge clk);
    end while (s);
    sb.note_char(c, last);
    words_sent++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) put_word(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  task automatic write_mode(bit m);
    char_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    psel <= 1; pwrite <= 1; paddr <= ADDR_MODE; pwdata <= {31'd0, m};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.mode = m;
  endtask

  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function automatic void push_field(int v);
    string s;
    int zeros;
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 2)) text_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    if (v < 0) text_q.push_back(CH_MINUS);
    else if ($urandom_range(0, 7) == 0) text_q.push_back(CH_PLUS);
    s = $sformatf("%0d", v < 0 ? -v : v);
    zeros = 0;
    if ($urandom_range(0, 5) == 0) zeros = $urandom_range(0, DIGIT_MAX - s.len());
    if ($urandom_range(0, 40) == 0) zeros = DIGIT_MAX + 1 - s.len();   // over-long number
    repeat (zeros) text_q.push_back(CH_ZERO);
    push_str(s);
  endfunction

  function automatic int pick(int lo, int hi);
    int v;
    if ($urandom_range(0, 99) < 88) return $urandom_range(lo, hi);
    v = $urandom_range(0, 3) == 0 ? $urandom_range(0, 999999999) : $urandom_range(0, 99);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic void make_text(bit stamp);
    push_field(pick(1900, 2100)); text_q.push_back(CH_MINUS);
    push_field(pick(1, 12));      text_q.push_back(CH_MINUS);
    push_field(pick(1, 31));
    if (stamp) begin
      case ($urandom_range(0, 3))
        0: ;
        1: text_q.push_back(CH_SPACE);
        2: text_q.push_back(CH_TAB);
        3: push_str("   ");
      endcase
      push_field(pick(0, 23)); text_q.push_back(CH_COLON);
      push_field(pick(0, 59)); text_q.push_back(CH_COLON);
      push_field(pick(0, 59));
      if ($urandom_range(0, 2) != 0) begin
        if ($urandom_range(0, 4) == 0) push_str(" z");
        text_q.push_back(CH_DOT);
        repeat ($urandom_range(0, 8)) text_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
      end
    end
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 5)) text_q.push_back(8'($urandom_range(32, 126)));
  endfunction

  function automatic void break_text();
    int pos;
    pos = $urandom_range(0, text_q.size() - 1);
    case ($urandom_range(0, 3))
      0: text_q[pos] = 8'($urandom_range(0, 255));
      1: while (text_q.size() > pos + 1) void'(text_q.pop_back());
      2: text_q.insert(pos, CH_NUL);
      3: while (text_q.size() < 70 && text_q.size() < $urandom_range(12, 70))
           text_q.push_back("x");
    endcase
  endfunction

  task automatic random_phase(bit m, int words);
    int goal, r;
    write_mode(m);
    goal = words_sent + words;
    while (words_sent < goal) begin
      r = $urandom_range(0, 99);
      if (r < 85) begin
        // mostly text of the form the mode expects, now and then the other form
        make_text($urandom_range(0, 9) == 0 ? m : !m);
        if (r >= 65) break_text();
      end else begin
        repeat ($urandom_range(1, 20)) text_q.push_back(8'($urandom_range(0, 255)));
      end
      send_text();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    write_mode(MODE_STAMP);
    push_str("2000-01-01 00:00:00"); send_text();
    push_str("1999-12-31 23:59:59.999999"); send_text();
    push_str("  +2024-  -02-29\t01:02:03.1234567xyz"); send_text();
    push_str("2000-01-0112:00:00.5"); send_text();
    push_str("-999999999-1-1 0:0:0."); send_text();
    push_str("999999999-99-99 99:99:99 q.7"); send_text();
    push_str("0000000001-01-01 00:00:00"); send_text();
    push_str("2000-01-01 00:00"); send_text();
    push_str("2000/01/01 00:00:00"); send_text();
    push_str("+-1-1-1 0:0:0"); send_text();
    push_str("2000-01-01 00:00:07"); text_q.push_back(CH_NUL); push_str("junk"); send_text();
    push_str("2000-01"); text_q.push_back(CH_NUL); push_str("-01 0:0:0"); send_text();
    push_str("2000-01-01 00:00:00.000001 ____________________"); send_text();
    push_str("2000-01-01 00:00:00.000001 _____________________"); send_text();
    push_str("5"); send_text();
    text_q.push_back(CH_NUL); send_text();

    write_mode(MODE_DATE);
    push_str("2000-01-01"); send_text();
    push_str("2000-03-01junk"); send_text();
    push_str("-5-3-1"); send_text();
    push_str("1-1-1 12:00:00"); send_text();
    push_str("2000-01-01 23456"); send_text();
    push_str("2000-01-01 234567"); send_text();
    push_str("2000-01-"); send_text();

    random_phase(MODE_STAMP, RANDOM_WORDS / 4);
    random_phase(MODE_DATE, RANDOM_WORDS / 4);
    calm = 1;
    random_phase(MODE_STAMP, RANDOM_WORDS / 6);
    calm = 0;
    random_phase(MODE_STAMP, RANDOM_WORDS / 6);
    random_phase(MODE_DATE, RANDOM_WORDS / 6);

    char_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule
